@@ design/hns_pkg.sv @@
// Package for the heightmap normal stencil block.
// Holds the fixed datapath widths, register indexes and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package hns_pkg;

  localparam int CNT_W   = 11;  // counters and effective geometry
  localparam int SLOPE_W = 12;  // summed slopes, at most 1530 in magnitude
  localparam int PROD_W  = 27;  // magnitude of a scaled vector component
  localparam int SQ_W    = 54;  // square of one component
  localparam int Q_W     = 55;  // squared length of the vector
  localparam int T_W     = 70;  // quantizer compare width

  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_HORIZ_SCALE  = 2'd2;
  localparam logic [1:0] CFG_VERT_SCALE   = 2'd3;

  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  localparam logic signed [7:0] NORMAL_FULL = 8'sd127;

  typedef struct packed {
    logic             rd;        // latch sample, read line stores at col
    logic [CNT_W-1:0] col;
    logic             shift;     // shift window; with wr, write line stores
    logic             wr;
    logic             drain;
    logic             slope;
    logic             center_right;
    logic             left;
    logic             right;
    logic             top;
    logic             bottom;
    logic             mul;
    logic             sq;
    logic [1:0]       comp;
    logic             sum;
    logic             qinit;
    logic             qiter;
    logic [2:0]       bitj;
    logic             load_out;
    logic             done;
    logic             last;
  } hns_cmd_t;

  typedef struct packed {
    logic q_zero;
  } hns_stat_t;

endpackage

@@ design/hns_if.sv @@
// Stream interfaces for height samples in and normals out.
// Depends on nothing; each carries valid, ready and the word payload.
`timescale 1ns / 1ps

interface hns_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] height_sample;

  modport source (output valid, kind, height_sample, input ready);
  modport sink (input valid, kind, height_sample, output ready);
endinterface

interface hns_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] normal_x;
  logic signed [7:0] normal_y;
  logic signed [7:0] normal_z;
  logic              frame_done;
  logic              run_last;

  modport source (output valid, normal_x, normal_y, normal_z, frame_done, run_last,
                  input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, frame_done, run_last,
                output ready);
endinterface

@@ design/hns_dp.sv @@
// Datapath: line stores, 3x3 window, slope sums, scaling, squares and quantizer.
// Depends on hns_pkg; driven by commands from hns_ctrl.
`timescale 1ns / 1ps

module hns_dp #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  hns_pkg::hns_cmd_t  cmd,
  input  logic [7:0]         height_sample,
  input  logic [15:0]        horizontal_scale,
  input  logic [15:0]        vertical_scale,
  output hns_pkg::hns_stat_t stat,
  output logic signed [7:0]  normal_x,
  output logic signed [7:0]  normal_y,
  output logic signed [7:0]  normal_z,
  output logic               frame_done,
  output logic               run_last
);
  import hns_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [7:0] upper_mem [MAX_WIDTH];
  logic [7:0] middle_mem [MAX_WIDTH];
  logic [7:0] up_rd, mid_rd, sample;
  logic [AW-1:0] addr;

  logic [7:0] win [3][3];

  logic signed [SLOPE_W-1:0] sum_x, sum_z;
  logic [PROD_W-1:0] mag [3];
  logic neg_x, neg_z;
  logic [SQ_W-1:0] sqr [3];
  logic [Q_W-1:0] q;
  logic q_zero;
  logic [T_W-1:0] target, s_acc, n_acc;
  logic [6:0] n_val;
  logic [7:0] res [3];

  // Line stores, read and written in clocked blocks.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      up_rd  <= upper_mem[AW'(cmd.col)];
      mid_rd <= middle_mem[AW'(cmd.col)];
      addr   <= AW'(cmd.col);
      sample <= height_sample;
    end
    if (cmd.shift && cmd.wr) begin
      upper_mem[addr]  <= mid_rd;
      middle_mem[addr] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          win[c][r] <= 8'd0;
        end
      end
    end else if (cmd.shift) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2][0] <= up_rd;
      win[2][1] <= mid_rd;
      win[2][2] <= cmd.drain ? mid_rd : sample;
    end
  end

  // Clamped stencil taps.
  logic [1:0] col_c, col_l, col_r, row_u, row_d;
  logic signed [SLOPE_W-1:0] sx, sy, sxy, syx, sx2, sy2, sxy2, syx2;

  function automatic logic signed [SLOPE_W-1:0] px(input logic [7:0] v);
    px = $signed({{(SLOPE_W-8){1'b0}}, v});
  endfunction

  always_comb begin
    col_c = cmd.center_right ? 2'd2 : 2'd1;
    col_l = cmd.left ? col_c : col_c - 2'd1;
    col_r = (cmd.right && !cmd.center_right) ? 2'd1 : 2'd2;
    row_u = cmd.top ? 2'd1 : 2'd0;
    row_d = cmd.bottom ? 2'd1 : 2'd2;
    sx  = px(win[col_r][1]) - px(win[col_l][1]);
    sy  = px(win[col_c][row_d]) - px(win[col_c][row_u]);
    sxy = px(win[col_r][row_d]) - px(win[col_l][row_u]);
    syx = px(win[col_r][row_u]) - px(win[col_l][row_d]);
    sx2  = (cmd.left || cmd.right) ? (sx <<< 1) : sx;
    sy2  = (cmd.top || cmd.bottom) ? (sy <<< 1) : sy;
    sxy2 = ((cmd.top && cmd.left) || (cmd.bottom && cmd.right)) ? (sxy <<< 1) : sxy;
    syx2 = ((cmd.top && cmd.right) || (cmd.bottom && cmd.left)) ? (syx <<< 1) : syx;
  end

  logic signed [SLOPE_W+16:0] vx, vz;
  logic [SLOPE_W+16:0] ax, az;
  always_comb begin
    vx = sum_x * $signed({1'b0, vertical_scale});
    vz = sum_z * $signed({1'b0, vertical_scale});
    ax = vx[SLOPE_W+16] ? 29'(-vx) : 29'(vx);
    az = vz[SLOPE_W+16] ? 29'(-vz) : 29'(vz);
  end

  // Quantizer trial: (n | 2^j)^2 * q built from n^2*q and n*q by shifts.
  logic [T_W-1:0] trial, q_ext, a2_ext;
  logic [6:0] n_next;
  logic ok;
  logic [7:0] n_wide;
  always_comb begin
    q_ext  = T_W'(q);
    a2_ext = T_W'(sqr[cmd.comp]);
    trial  = s_acc + (n_acc << ({1'b0, cmd.bitj} + 4'd1)) + (q_ext << {cmd.bitj, 1'b0});
    ok     = trial <= target;
    n_next = ok ? (n_val | (7'd1 << cmd.bitj)) : n_val;
    n_wide = {1'b0, n_next};
  end

  logic comp_neg;
  assign comp_neg = (cmd.comp == COMP_X) ? neg_x : ((cmd.comp == COMP_Z) ? !neg_z : 1'b0);

  always_ff @(posedge clk) begin
    if (cmd.slope) begin
      sum_x <= sx2 + sxy2 + syx2;
      sum_z <= sy2 + sxy2 - syx2;
    end
    if (cmd.mul) begin
      mag[0] <= ax[PROD_W-1:0];
      mag[1] <= {{(PROD_W-18){1'b0}}, horizontal_scale, 2'b00};
      mag[2] <= az[PROD_W-1:0];
      neg_x  <= vx[SLOPE_W+16];
      neg_z  <= vz[SLOPE_W+16] || (vz == '0);
    end
    if (cmd.sq) begin
      sqr[cmd.comp] <= mag[cmd.comp] * mag[cmd.comp];
    end
    if (cmd.sum) begin
      q      <= Q_W'(sqr[0]) + Q_W'(sqr[1]) + Q_W'(sqr[2]);
      q_zero <= (sqr[0] == '0) && (sqr[1] == '0) && (sqr[2] == '0);
    end
    if (cmd.qinit) begin
      target <= (a2_ext << 14) - (a2_ext << 8) + a2_ext;
      s_acc  <= '0;
      n_acc  <= '0;
      n_val  <= '0;
    end
    if (cmd.qiter) begin
      if (ok) begin
        s_acc <= trial;
        n_acc <= n_acc + (q_ext << cmd.bitj);
      end
      n_val <= n_next;
      if (cmd.bitj == 3'd0) begin
        res[cmd.comp] <= comp_neg ? (8'd0 - n_wide) : n_wide;
      end
    end
    if (cmd.load_out) begin
      normal_x   <= q_zero ? 8'sd0 : $signed(res[0]);
      normal_y   <= q_zero ? NORMAL_FULL : $signed(res[1]);
      normal_z   <= q_zero ? 8'sd0 : $signed(res[2]);
      frame_done <= cmd.done;
      run_last   <= cmd.last;
    end
  end

  assign stat.q_zero = (sqr[0] == '0) && (sqr[1] == '0) && (sqr[2] == '0);

endmodule

@@ design/hns_ctrl.sv @@
// Controller: frame counters, pixel emission and sequencing of the datapath.
// Depends on hns_pkg; drives hns_dp through hns_cmd_t.
`timescale 1ns / 1ps

module hns_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_kind,
  output logic                         in_ready,
  input  logic                         out_ready,
  output logic                         out_valid,
  input  logic [hns_pkg::CNT_W-1:0]    width,
  input  logic [hns_pkg::CNT_W-1:0]    height,
  input  hns_pkg::hns_stat_t           stat,
  output hns_pkg::hns_cmd_t            cmd
);
  import hns_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_UPD   = 4'd1;
  localparam logic [3:0] S_SLOPE = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_SQ    = 4'd4;
  localparam logic [3:0] S_SUM   = 4'd5;
  localparam logic [3:0] S_QINIT = 4'd6;
  localparam logic [3:0] S_QITER = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state;
  logic [CNT_W-1:0] column_count, row_count, drain_count;
  logic [CNT_W-1:0] cur_c, cur_r, ypix;
  logic is_drain, has1, sel;
  logic [1:0] comp;
  logic [2:0] bitj;

  logic accept, ignore, restart, lastcol, emit0, emit1, can_load;
  logic [CNT_W-1:0] c_eff, x_pix, wm1, hm1;

  always_comb begin
    wm1     = width - 11'd1;
    hm1     = height - 11'd1;
    accept  = in_valid && in_ready;
    ignore  = in_kind && (drain_count == '0);
    restart = !in_kind && (drain_count != '0);
    c_eff   = restart ? '0 : column_count;
    lastcol = cur_c >= wm1;
    emit0   = (cur_c != '0) && (is_drain || (cur_r != '0));
    emit1   = lastcol && (is_drain || (cur_r != '0));
    x_pix   = sel ? cur_c : cur_c - 11'd1;
    can_load = !out_valid || out_ready;
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.rd           = accept && !ignore;
    cmd.col          = c_eff;
    cmd.shift        = (state == S_UPD);
    cmd.wr           = !is_drain;
    cmd.drain        = is_drain;
    cmd.slope        = (state == S_SLOPE);
    cmd.center_right = sel;
    cmd.left         = (x_pix == '0);
    cmd.right        = x_pix >= wm1;
    cmd.top          = (ypix == '0);
    cmd.bottom       = ypix >= hm1;
    cmd.mul          = (state == S_MUL);
    cmd.sq           = (state == S_SQ);
    cmd.comp         = comp;
    cmd.sum          = (state == S_SUM);
    cmd.qinit        = (state == S_QINIT);
    cmd.qiter        = (state == S_QITER);
    cmd.bitj         = bitj;
    cmd.load_out     = (state == S_OUT) && can_load;
    cmd.done         = sel && is_drain;
    cmd.last         = sel || !has1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      column_count <= '0;
      row_count    <= '0;
      drain_count  <= '0;
      out_valid    <= 1'b0;
      sel          <= 1'b0;
      comp         <= COMP_X;
      bitj         <= 3'd6;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && !ignore) begin
            if (restart) begin
              drain_count  <= '0;
              column_count <= '0;
              row_count    <= '0;
            end
            cur_c    <= c_eff;
            cur_r    <= restart ? '0 : row_count;
            is_drain <= in_kind;
            state    <= S_UPD;
          end
        end
        S_UPD: begin
          has1 <= emit1;
          ypix <= is_drain ? hm1 : cur_r - 11'd1;
          if (is_drain) begin
            if (lastcol || (drain_count == 11'd1)) begin
              drain_count  <= '0;
              column_count <= '0;
            end else begin
              drain_count  <= drain_count - 11'd1;
              column_count <= cur_c + 11'd1;
            end
          end else if (lastcol) begin
            column_count <= '0;
            if (cur_r >= hm1) begin
              row_count   <= '0;
              drain_count <= width;
            end else begin
              row_count <= cur_r + 11'd1;
            end
          end else begin
            column_count <= cur_c + 11'd1;
          end
          sel <= !emit0;
          state <= (emit0 || emit1) ? S_SLOPE : S_IDLE;
        end
        S_SLOPE: state <= S_MUL;
        S_MUL: begin
          comp  <= COMP_X;
          state <= S_SQ;
        end
        S_SQ: begin
          if (comp == COMP_Z) begin
            state <= S_SUM;
          end else begin
            comp <= comp + 2'd1;
          end
        end
        S_SUM: begin
          comp  <= COMP_X;
          state <= stat.q_zero ? S_OUT : S_QINIT;
        end
        S_QINIT: begin
          bitj  <= 3'd6;
          state <= S_QITER;
        end
        S_QITER: begin
          if (bitj == 3'd0) begin
            if (comp == COMP_Z) begin
              state <= S_OUT;
            end else begin
              comp  <= comp + 2'd1;
              state <= S_QINIT;
            end
          end else begin
            bitj <= bitj - 3'd1;
          end
        end
        S_OUT: begin
          if (can_load) begin
            if (!sel && has1) begin
              sel   <= 1'b1;
              state <= S_SLOPE;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");
  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_UPD || state == S_IDLE))
    else $error("accepted word did not start an update");
  a_iter_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_QITER && bitj != 3'd0) |=> (state == S_QITER))
    else $error("quantizer search cut short");
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (state == S_IDLE && !out_valid))
    else $error("reset did not clear control state");
`endif

endmodule

@@ design/heightmap_normal_stencil_top.sv @@
// A word yielding normals passes, after its update step, for each normal through slope,
// scaling, squares, sum and quantizer before the output load; an all-zero vector skips the
// search. A word yielding none is done after its update step. The block takes no new word
// until the last is through, held by the quantizer's seven-step bit search, run once
// per vector component on one shared compare unit; a normal waiting for the sink holds it too.
// Reset (synchronous, active high) clears counters, window and handshakes, not line stores.
`timescale 1ns / 1ps

module heightmap_normal_stencil_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  hns_in_if.sink      pixels,
  hns_out_if.source   normals,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import hns_pkg::*;

  // Configuration registers. The user must write them only while the block is idle; it does not check.
  logic [CNT_W-1:0] frame_width, frame_height;
  logic [15:0] horizontal_scale, vertical_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width      <= 11'd1024;
      frame_height     <= 11'd1024;
      horizontal_scale <= 16'd256;
      vertical_scale   <= 16'd256;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width      <= cfg_data[CNT_W-1:0];
        CFG_FRAME_HEIGHT: frame_height     <= cfg_data[CNT_W-1:0];
        CFG_HORIZ_SCALE:  horizontal_scale <= cfg_data;
        CFG_VERT_SCALE:   vertical_scale   <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero dimension behaves as one; a width past the line store depth, or a height past MAX_HEIGHT, is clipped.
  logic [CNT_W-1:0] width_eff, height_eff;
  always_comb begin
    if (frame_width == '0) begin
      width_eff = 11'd1;
    end else if (32'(frame_width) > MAX_WIDTH) begin
      width_eff = CNT_W'(MAX_WIDTH);
    end else begin
      width_eff = frame_width;
    end
    if (frame_height == '0) begin
      height_eff = 11'd1;
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      height_eff = CNT_W'(MAX_HEIGHT);
    end else begin
      height_eff = frame_height;
    end
  end

  hns_cmd_t  cmd;
  hns_stat_t stat;

  // The controller owns the counters and the handshakes; the datapath holds the line
  // stores, the window and the normalizer, plus the output word register.
  hns_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixels.valid),
    .in_kind   (pixels.kind),
    .in_ready  (pixels.ready),
    .out_ready (normals.ready),
    .out_valid (normals.valid),
    .width     (width_eff),
    .height    (height_eff),
    .stat      (stat),
    .cmd       (cmd)
  );

  hns_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .height_sample    (pixels.height_sample),
    .horizontal_scale (horizontal_scale),
    .vertical_scale   (vertical_scale),
    .stat             (stat),
    .normal_x         (normals.normal_x),
    .normal_y         (normals.normal_y),
    .normal_z         (normals.normal_z),
    .frame_done       (normals.frame_done),
    .run_last         (normals.run_last)
  );

endmodule

@@ tb/tb.sv @@
// Testbench for heightmap_normal_stencil_top: streams height samples and drain words,
// predicts every quantized normal and checks it. Depends on hns_pkg and the
// interfaces hns_in_if / hns_out_if.
`timescale 1ns / 1ps

module tb;
  import hns_pkg::*;

  localparam int LINE_DEPTH = 1024;
  localparam int CYCLE_LIMIT = 2000000;
  // A word with no normal needs only its update step; one with normals also runs the
  // quantizer for each, and this pause covers any word still in flight.
  localparam int SETTLE_CYCLES = 80;

  typedef struct {
    bit       kind;
    bit [7:0] height;
  } pixel_word_t;

  typedef struct {
    logic signed [7:0] nx;
    logic signed [7:0] ny;
    logic signed [7:0] nz;
    bit                done;
    bit                last;
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = CFG_FRAME_WIDTH;
  logic [15:0] cfg_data = '0;

  hns_in_if  pixels ();
  hns_out_if normals ();

  heightmap_normal_stencil_top u_dut (
    .clk(clk), .rst(rst), .pixels(pixels), .normals(normals),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Words waiting to be sent and normals waiting to arrive.
  pixel_word_t word_q[$];
  normal_t     normal_q[$];

  int errors = 0;
  int words_sent = 0;
  int normals_seen = 0;
  int frames_built = 0;
  longint cycles = 0;
  bit calm = 1'b0;   // no idling on either side once set

  // Shadow of the block: geometry, scales, line stores, window and counters.
  bit [10:0] shadow_width = 11'd1024;
  bit [10:0] shadow_height = 11'd1024;
  bit [15:0] shadow_hscale = 16'd256;
  bit [15:0] shadow_vscale = 16'd256;
  bit [7:0]  upper_store[LINE_DEPTH];
  bit [7:0]  middle_store[LINE_DEPTH];
  bit [7:0]  window[3][3];  // [column oldest..newest][row above, center, below]
  int unsigned col_pos, row_pos, drain_left;

  task automatic report(string what, int got, int want);
    $display("tb: mismatch on %s: got %0d, expected %0d (normal %0d)",
             what, got, want, normals_seen);
    errors++;
  endtask

  function automatic int unsigned clamp_dim(bit [10:0] v);
    if (v == 0) return 1;
    if (v > LINE_DEPTH) return LINE_DEPTH;
    return v;
  endfunction

  // trunc(127 * v / sqrt(q)): the largest n with n*n*q <= 16129*v*v, signed like v.
  function automatic logic signed [7:0] quantize(longint v, longint unsigned q);
    logic [127:0] mag, bound, trial;
    int n;
    mag = (v < 0) ? -v : v;
    bound = mag * mag * 128'd16129;
    for (n = 127; n > 0; n--) begin
      trial = 128'(n) * 128'(n) * 128'(q);
      if (trial <= bound) break;
    end
    return (v < 0) ? -8'(n) : 8'(n);
  endfunction

  // One window tap, with the clamp to the edge folded in.
  function automatic int window_tap(int cc, int dx, int dy, bit l, bit r, bit t, bit b);
    int c, rw;
    c = cc;
    rw = 1;
    if (dx < 0 && !l) c = cc - 1;
    if (dx > 0 && !r) c = cc + 1;
    if (dy < 0 && !t) rw = 0;
    if (dy > 0 && !b) rw = 2;
    if (c > 2) c = 2;
    return window[c][rw];
  endfunction

  task automatic predict_normal(int cc, int unsigned x, int unsigned y, bit done_flag);
    int unsigned w, h;
    bit l, r, t, b;
    int sx, sy, sxy, syx;
    longint vx, vy, vz;
    longint unsigned q;
    normal_t n;
    w = clamp_dim(shadow_width);
    h = clamp_dim(shadow_height);
    l = (x == 0);
    r = (x >= w - 1);
    t = (y == 0);
    b = (y >= h - 1);
    sx  = window_tap(cc, 1, 0, l, r, t, b) - window_tap(cc, -1, 0, l, r, t, b);
    sy  = window_tap(cc, 0, 1, l, r, t, b) - window_tap(cc, 0, -1, l, r, t, b);
    sxy = window_tap(cc, 1, 1, l, r, t, b) - window_tap(cc, -1, -1, l, r, t, b);
    syx = window_tap(cc, 1, -1, l, r, t, b) - window_tap(cc, -1, 1, l, r, t, b);
    // Border slopes are one-sided, so they get doubled.
    if (l || r) sx *= 2;
    if (t || b) sy *= 2;
    if ((t && l) || (b && r)) sxy *= 2;
    if ((t && r) || (b && l)) syx *= 2;
    vx = longint'(sx + sxy + syx) * longint'(shadow_vscale);
    vy = 4 * longint'(shadow_hscale);
    vz = -longint'(sy + sxy - syx) * longint'(shadow_vscale);
    q = vx * vx + vy * vy + vz * vz;
    if (q == 0) begin
      n.nx = 0; n.ny = NORMAL_FULL; n.nz = 0;
    end else begin
      n.nx = quantize(vx, q); n.ny = quantize(vy, q); n.nz = quantize(vz, q);
    end
    n.done = done_flag;
    n.last = 1'b0;
    normal_q = {normal_q, n};
  endtask

  task automatic shift_window(bit [7:0] a, bit [7:0] m, bit [7:0] s);
    window[0] = window[1];
    window[1] = window[2];
    window[2][0] = a; window[2][1] = m; window[2][2] = s;
  endtask

  // Advance the shadow by one accepted word and queue the normals it yields.
  task automatic predict_word(pixel_word_t wd);
    int unsigned w, h, c, r, idx, queued;
    bit lastc;
    w = clamp_dim(shadow_width);
    h = clamp_dim(shadow_height);
    queued = normal_q.size();
    if (wd.kind) begin
      if (drain_left == 0) return;  // a drain with nothing pending is ignored
      c = col_pos;
      idx = c % LINE_DEPTH;
      lastc = (c >= w - 1);
      shift_window(upper_store[idx], middle_store[idx], middle_store[idx]);
      if (c >= 1) predict_normal(1, c - 1, h - 1, 1'b0);
      if (lastc) predict_normal(2, c, h - 1, 1'b1);
      if (lastc) begin
        drain_left = 0;
        col_pos = 0;
      end else begin
        drain_left = (drain_left - 1) & 11'h7ff;
        col_pos = c + 1;
      end
      if (drain_left == 0) col_pos = 0;
    end else begin
      // A sample while the drain is armed abandons the pending last row.
      if (drain_left != 0) begin
        drain_left = 0; col_pos = 0; row_pos = 0;
      end
      c = col_pos;
      r = row_pos;
      idx = c % LINE_DEPTH;
      lastc = (c >= w - 1);
      shift_window(upper_store[idx], middle_store[idx], wd.height);
      upper_store[idx] = middle_store[idx];
      middle_store[idx] = wd.height;
      if (r >= 1) begin
        if (c >= 1) predict_normal(1, c - 1, r - 1, 1'b0);
        if (lastc) predict_normal(2, c, r - 1, 1'b0);
      end
      if (lastc) begin
        col_pos = 0;
        if (r >= h - 1) begin
          row_pos = 0;
          drain_left = w & 11'h7ff;
        end else begin
          row_pos = r + 1;
        end
      end else begin
        col_pos = c + 1;
      end
    end
    if (normal_q.size() > queued) normal_q[$].last = 1'b1;
  endtask

  // Driver: presents the next queued word, with random bursts of idle cycles.
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      pixels.valid <= 1'b0;
      pixels.kind <= 1'b0;
      pixels.height_sample <= '0;
    end else begin
      if (pixels.valid && pixels.ready) begin
        predict_word('{kind: pixels.kind, height: pixels.height_sample});
        words_sent++;
      end
      if (!pixels.valid || pixels.ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          pixels.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          in_gap <= $urandom_range(0, 7);
          pixels.valid <= 1'b0;
        end else if (word_q.size() > 0) begin
          pixels.kind <= word_q[0].kind;
          pixels.height_sample <= word_q[0].height;
          pixels.valid <= 1'b1;
          void'(word_q.pop_front());
        end else begin
          pixels.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted normal against the oldest prediction and
  // stalls the output side in random bursts.
  int out_gap = 0;
  always @(posedge clk) begin
    normal_t want;
    cycles <= cycles + 1;
    if (rst) begin
      normals.ready <= 1'b0;
    end else begin
      if (normals.valid && normals.ready) begin
        normals_seen++;
        if (normal_q.size() == 0) begin
          report("unexpected normal", 1, 0);
        end else begin
          want = normal_q.pop_front();
          if (normals.normal_x !== want.nx) report("normal_x", normals.normal_x, want.nx);
          if (normals.normal_y !== want.ny) report("normal_y", normals.normal_y, want.ny);
          if (normals.normal_z !== want.nz) report("normal_z", normals.normal_z, want.nz);
          if (normals.frame_done !== want.done)
            report("frame_done", normals.frame_done, want.done);
          if (normals.run_last !== want.last) report("run_last", normals.run_last, want.last);
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        normals.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 7);
        normals.ready <= 1'b0;
      end else begin
        normals.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic send(bit k, bit [7:0] h);
    pixel_word_t wd;
    wd.kind = k;
    wd.height = h;
    word_q = {word_q, wd};
  endtask

  // Heights lean on the extremes so that the largest slopes come up often.
  function automatic bit [7:0] pick_height();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic bit [15:0] pick_scale();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'd256;
      3: return 16'($urandom_range(1, 1024));
      default: return 16'($urandom);
    endcase
  endfunction

  // Waits until the block has taken every word and delivered every normal.
  task automatic wait_idle();
    wait (word_q.size() == 0 && normal_q.size() == 0 && !pixels.valid);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, bit [15:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      CFG_FRAME_WIDTH:  shadow_width = value[10:0];
      CFG_FRAME_HEIGHT: shadow_height = value[10:0];
      CFG_HORIZ_SCALE:  shadow_hscale = value;
      CFG_VERT_SCALE:   shadow_vscale = value;
      default: ;
    endcase
  endtask

  task automatic configure(bit [10:0] w, bit [10:0] h, bit [15:0] hs, bit [15:0] vs);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 16'(w));
    write_reg(CFG_FRAME_HEIGHT, 16'(h));
    write_reg(CFG_HORIZ_SCALE, hs);
    write_reg(CFG_VERT_SCALE, vs);
    cfg_write <= 1'b0;
  endtask

  // A whole frame of random samples, at times after a stray drain, then its drain: mostly
  // complete, sometimes cut short (the next frame abandons it), sometimes followed by stray drains.
  task automatic random_frame(bit may_cut);
    int unsigned w, h, i, drains;
    w = clamp_dim(shadow_width);
    h = clamp_dim(shadow_height);
    if ($urandom_range(0, 9) == 0) send(1'b1, 8'($urandom));
    for (i = 0; i < w * h; i++) send(1'b0, pick_height());
    drains = w;
    if (may_cut && $urandom_range(0, 9) == 0) drains = $urandom_range(0, w - 1);
    else if ($urandom_range(0, 9) == 0) drains = w + $urandom_range(1, 3);
    for (i = 0; i < drains; i++) send(1'b1, 8'($urandom));
    frames_built++;
  endtask

  task automatic random_phases(int unsigned budget);
    int unsigned start, f, nf;
    start = words_sent + word_q.size();
    while (words_sent + word_q.size() - start < budget) begin
      configure(11'($urandom_range(0, 8)), 11'($urandom_range(0, 6)),
                pick_scale(), pick_scale());
      nf = $urandom_range(1, 3);
      for (f = 0; f < nf; f++) random_frame(f + 1 < nf);
    end
  endtask

  initial begin
    int i;
    col_pos = 0; row_pos = 0; drain_left = 0;
    for (i = 0; i < LINE_DEPTH; i++) begin
      upper_store[i] = '0;
      middle_store[i] = '0;
    end
    window = '{default: '{default: 8'd0}};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a 3x3 frame of extreme heights covers all four corners, every
    // edge and the interior; then a stray drain with nothing armed.
    configure(11'd3, 11'd3, 16'd256, 16'd256);
    send(1'b0, 8'd0);   send(1'b0, 8'd255); send(1'b0, 8'd0);
    send(1'b0, 8'd255); send(1'b0, 8'd0);   send(1'b0, 8'd255);
    send(1'b0, 8'd255); send(1'b0, 8'd255); send(1'b0, 8'd0);
    send(1'b1, 8'd0); send(1'b1, 8'd0); send(1'b1, 8'd255);
    send(1'b1, 8'd0);
    // A single-pixel frame: every border at once, done on the only normal.
    configure(11'd1, 11'd1, 16'd256, 16'd256);
    send(1'b0, 8'd200); send(1'b1, 8'd0);
    // Both scales zero give the all-zero vector.
    configure(11'd1, 11'd1, 16'd0, 16'd0);
    send(1'b0, 8'd255); send(1'b1, 8'd0);
    // Horizontal scale zero with the largest height scale: normals lie flat.
    configure(11'd2, 11'd2, 16'd0, 16'hffff);
    send(1'b0, 8'd0); send(1'b0, 8'd255); send(1'b0, 8'd255); send(1'b0, 8'd0);
    send(1'b1, 8'd0); send(1'b1, 8'd0);

    random_phases(200);

    // Widest frame (a width past the maximum acts as the maximum), one row
    // high (zero acts as one). Only part of it is drained; the next frame
    // abandons the rest.
    configure(11'h7ff, 11'd0, pick_scale(), pick_scale());
    for (i = 0; i < LINE_DEPTH; i++) send(1'b0, pick_height());
    for (i = 0; i < 30; i++) send(1'b1, 8'd0);

    random_phases(300);

    // Last stretch runs with both sides flat out.
    wait_idle();
    calm = 1'b1;
    random_phases(150);

    // Tallest frame, one column wide; it is left unfinished at the end of the run.
    configure(11'd1, 11'd1024, pick_scale(), pick_scale());
    for (i = 0; i < 120; i++) send(1'b0, pick_height());

    wait (word_q.size() == 0 && normal_q.size() == 0 && !pixels.valid);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (normal_q.size() != 0) report("normals never delivered", 0, normal_q.size());

    $display("tb: %0d words sent over %0d random frames plus directed ones, %0d normals",
             words_sent, frames_built, normals_seen);
    $display("tb: geometry from 1x1 to full width and height, scales 0 to 65535");
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

@@ heightmap_normal_stencil_top.f @@
design/hns_pkg.sv
design/hns_if.sv
design/hns_dp.sv
design/hns_ctrl.sv
design/heightmap_normal_stencil_top.sv
tb/tb.sv
